// ===== sv/dssw_pkg.sv =====
// ----------------------------------------------------------------------------
// dssw_pkg
// Shared types, constants and the segment table of the decimal
// seven-segment writer.
// ----------------------------------------------------------------------------
package dssw_pkg;

    // Field widths
    localparam int NUMBER_W    = 32;
    localparam int VALUE_W     = 27;   // holds any value up to the range limit
    localparam int ADDR_W      = 4;
    localparam int SEG_W       = 8;
    localparam int DIGIT_W     = 4;

    // Digit positions per number
    localparam int DIGIT_COUNT = 8;
    localparam int IDX_W       = $clog2(DIGIT_COUNT);

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Largest value that still fits on eight digits
    localparam logic [NUMBER_W-1:0] RANGE_LIMIT = 32'd99999999;

    // Divide by ten: q = (x * RECIP_10) >> RECIP_SHIFT, exact for x < 2**27
    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = 31;
    localparam logic [RECIP_W-1:0] RECIP_10 = 28'd214748365;

    // Segment patterns that are not decimal digits
    localparam logic [SEG_W-1:0] PAT_DOT   = 8'h80;
    localparam logic [SEG_W-1:0] PAT_BLANK = 8'h00;

    // Classes of a number
    typedef logic [1:0] t_cls;
    localparam t_cls CLS_DIGITS = 2'd0;
    localparam t_cls CLS_ZERO   = 2'd1;
    localparam t_cls CLS_OVER   = 2'd2;

    // Queue word between front and back
    typedef struct packed {
        t_cls                cls;
        logic [VALUE_W-1:0]  value;
    } t_item;

    // Seven-segment pattern of one decimal digit, bit0 is segment a
    function automatic logic [SEG_W-1:0] seg_of_digit(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] pat;
        case (digit)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = PAT_BLANK;
        endcase
        return pat;
    endfunction

endpackage

// ===== sv/dssw_in_if.sv =====
// ----------------------------------------------------------------------------
// dssw_in_if
// Input channel: one number per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dssw_in_if;

    logic                           valid;
    logic                           ready;
    logic [dssw_pkg::NUMBER_W-1:0]  number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);

endinterface

// ===== sv/dssw_out_if.sv =====
// ----------------------------------------------------------------------------
// dssw_out_if
// Output channel: one display write per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dssw_out_if;

    logic                           valid;
    logic                           ready;
    logic [dssw_pkg::ADDR_W-1:0]    grid_address;
    logic [dssw_pkg::SEG_W-1:0]     segment_byte;
    logic                           last;

    modport source (output valid, output grid_address, output segment_byte,
                    output last, input ready);
    modport sink   (input valid, input grid_address, input segment_byte,
                    input last, output ready);

endinterface

// ===== sv/dssw_front.sv =====
// ----------------------------------------------------------------------------
// dssw_front
// Accepts numbers and sorts them into zero, over range and plain digits
// before they enter the queue.
// ----------------------------------------------------------------------------
module dssw_front (
    dssw_in_if.sink             i_in,
    output logic                o_push_valid,
    output dssw_pkg::t_item     o_push_item,
    input  logic                i_full
);

    dssw_pkg::t_cls cls;

    // Classify the incoming number
    always_comb begin
        if (i_in.number == '0) begin
            cls = dssw_pkg::CLS_ZERO;
        end else if (i_in.number > dssw_pkg::RANGE_LIMIT) begin
            cls = dssw_pkg::CLS_OVER;
        end else begin
            cls = dssw_pkg::CLS_DIGITS;
        end
    end

    // Only plain numbers carry a value into the back end
    always_comb begin
        o_push_item.cls   = cls;
        o_push_item.value = (cls == dssw_pkg::CLS_DIGITS) ?
                            i_in.number[dssw_pkg::VALUE_W-1:0] : '0;
    end

    assign i_in.ready   = !i_full;
    assign o_push_valid = i_in.valid && !i_full;

endmodule

// ===== sv/dssw_queue.sv =====
// ----------------------------------------------------------------------------
// dssw_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module dssw_queue #(
    parameter int DEPTH = dssw_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dssw_pkg::t_item     i_push_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_head_valid,
    output dssw_pkg::t_item     o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dssw_pkg::t_item    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Pointer and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ===== sv/dssw_back.sv =====
// ----------------------------------------------------------------------------
// dssw_back
// Digit engine: one divide-by-ten step per display write, with a registered
// output word toward the display side.
// ----------------------------------------------------------------------------
module dssw_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head_valid,
    input  dssw_pkg::t_item     i_head,
    output logic                o_pop,
    dssw_out_if.source          o_out
);

    localparam int PROD_W = dssw_pkg::VALUE_W + dssw_pkg::RECIP_W;
    localparam int VW     = dssw_pkg::VALUE_W;
    localparam int IW     = dssw_pkg::IDX_W;

    logic                           r_busy;
    dssw_pkg::t_cls                 r_cls;
    logic [VW-1:0]                  r_rest;
    logic [dssw_pkg::IDX_W-1:0]     r_idx;
    logic                           r_out_valid;
    logic [dssw_pkg::ADDR_W-1:0]    r_out_grid;
    logic [dssw_pkg::SEG_W-1:0]     r_out_seg;
    logic                           r_out_last;

    logic                           n_busy;
    logic [dssw_pkg::IDX_W-1:0]     n_idx;
    logic                           n_out_valid;

    logic                           step;
    logic                           at_last;
    logic                           load;
    logic [PROD_W-1:0]              prod;
    logic [VW-1:0]                  quot;
    logic [VW-1:0]                  rem_full;
    logic [dssw_pkg::DIGIT_W-1:0]   digit;
    logic [dssw_pkg::SEG_W-1:0]     pattern;

    // Handshake between engine, queue and output word
    assign at_last = (r_idx == IW'(dssw_pkg::DIGIT_COUNT - 1));
    assign step    = r_busy && (!r_out_valid || o_out.ready);
    assign load    = i_head_valid && (!r_busy || (step && at_last));
    assign o_pop   = load;

    // rest / 10 by reciprocal multiply, remainder by shift-add
    assign prod     = PROD_W'(r_rest) * PROD_W'(dssw_pkg::RECIP_10);
    assign quot     = VW'(prod >> dssw_pkg::RECIP_SHIFT);
    assign rem_full = r_rest - {quot[VW-4:0], 3'b000} - {quot[VW-2:0], 1'b0};
    assign digit    = rem_full[dssw_pkg::DIGIT_W-1:0];

    // Pattern of the current position
    always_comb begin
        if (r_idx == '0 && r_cls == dssw_pkg::CLS_ZERO) begin
            pattern = dssw_pkg::seg_of_digit('0);
        end else if (r_idx == '0 && r_cls == dssw_pkg::CLS_OVER) begin
            pattern = dssw_pkg::PAT_DOT;
        end else if (r_rest != '0) begin
            pattern = dssw_pkg::seg_of_digit(digit);
        end else begin
            pattern = dssw_pkg::PAT_BLANK;
        end
    end

    // Next control state
    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (step) begin
            n_idx       = r_idx + 1'b1;
            n_out_valid = 1'b1;
            if (at_last) begin
                n_busy = 1'b0;
            end
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Working value and output word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cls  <= i_head.cls;
            r_rest <= i_head.value;
        end else if (step) begin
            r_rest <= quot;
        end
        if (step) begin
            r_out_grid <= {~r_idx, 1'b0};
            r_out_seg  <= pattern;
            r_out_last <= at_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.grid_address = r_out_grid;
    assign o_out.segment_byte = r_out_seg;
    assign o_out.last         = r_out_last;

`ifndef NO_ASSERTIONS
    // Position counter rests at the first position while idle
    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_idx == '0)
        else $error("digit index not at first position while idle");

    // End marker only on the write to address zero
    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_grid == '0)
        else $error("end marker on a write other than address zero");

    // Eighth step produces the marked write
    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && at_last |=> r_out_valid && r_out_last)
        else $error("eighth write missing end marker");

    // Zero and over-range numbers carry no digits past the first position
    a_special_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cls != dssw_pkg::CLS_DIGITS |-> r_rest == '0)
        else $error("special number carries a nonzero value");
`endif

endmodule

// ===== sv/decimal_seven_segment_writer_unit.sv =====
// ----------------------------------------------------------------------------
// decimal_seven_segment_writer_unit
// Turns a 32-bit number into eight seven-segment display writes.
// ----------------------------------------------------------------------------
// Each accepted number yields eight output words, grid address 14 down to 0,
// least significant digit first, leading positions blank, zero shown as a
// single 0 and anything above 99999999 as a lone dot; the eighth word has
// last set. The output gives one word per cycle while the display side keeps
// ready high; the digit engine does one divide-by-ten step per word and loads
// the next number while it makes the last word of the one before. A number
// goes through the queue, working value register and output register; the
// queue takes up to QUEUE_DEPTH numbers ahead while engine or display is busy.
module decimal_seven_segment_writer_unit #(
    parameter int QUEUE_DEPTH = dssw_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dssw_in_if.sink     i_in,
    dssw_out_if.source  o_out
);

    logic               push_valid;
    dssw_pkg::t_item    push_item;
    logic               full;
    logic               pop;
    logic               head_valid;
    dssw_pkg::t_item    head;

    // Front: accept and classify
    dssw_front u_front (
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_full       (full)
    );

    // Queue between front and back
    dssw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_valid),
        .i_push_item  (push_item),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Back: digit engine and output word
    dssw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule
